// ----- sv/tpc_pkg.sv -----
// Shared types, constants and arithmetic helpers for the triangle plane clipper.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tpc_pkg;

    // Coordinate width (Q16.16) and derived widths
    localparam int CW      = 32;
    localparam int DW      = 67;   // plane distance, three 65-bit products summed
    localparam int RW      = 69;   // divider remainder and divisor
    localparam int NDIV    = 31;   // quotient bits, one per divider stage
    localparam int PW      = 64;   // edge delta times t
    localparam int NCFG    = 6;
    localparam int CFG_IW  = 3;
    localparam int TDATA_W = 9 * CW;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_POINT_X  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_POINT_Y  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_POINT_Z  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [CFG_IW-1:0] REG_NORMAL_Z = 3'd5;

    localparam logic [CW-1:0] RST_POINT_Z  = 32'd6554;
    localparam logic [CW-1:0] RST_NORMAL_Z = 32'd65536;

    // Vertex is [coord], triangle is [vertex][coord]; lowest index in lowest bits
    typedef logic [2:0][CW-1:0] t_vert;
    typedef logic [2:0][2:0][CW-1:0] t_tri;

    // One restoring-division stage
    typedef struct packed {
        logic [RW-1:0]   rem;
        logic [RW-1:0]   den;
        logic [NDIV-1:0] quo;
    } t_divst;

    // Data that rides alongside the divider
    typedef struct packed {
        t_tri       v;
        logic [1:0] ic;     // number of inside vertices
        logic [1:0] ea0;    // edge 0 inside end
        logic [1:0] eb0;    // edge 0 outside end
        logic [1:0] ea1;
        logic [1:0] eb1;
    } t_side;

    function automatic t_divst div_step(input t_divst s);
        logic [RW-1:0] sh;
        t_divst        r;
        sh    = {s.rem[RW-2:0], 1'b0};
        r.den = s.den;
        if (sh >= s.den) begin
            r.rem = sh - s.den;
            r.quo = {s.quo[NDIV-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.quo = {s.quo[NDIV-2:0], 1'b0};
        end
        return r;
    endfunction

    // Clamp a 34-bit signed value to the signed 32-bit range
    function automatic logic [CW-1:0] sat32(input logic signed [CW+1:0] v);
        logic [CW-1:0] r;
        if (v > $signed({3'b000, {(CW-1){1'b1}}})) begin
            r = {1'b0, {(CW-1){1'b1}}};
        end else if (v < $signed({3'b111, {(CW-1){1'b0}}})) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/tpc_div.sv -----
// Pipelined restoring divider producing the Q0.31 cut fraction t = num / den.
// Depends on tpc_pkg; one quotient bit per stage, advances with the block enable.
`timescale 1ns / 1ps

module tpc_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tpc_pkg::RW-1:0]    i_num,
    input  logic [tpc_pkg::RW-1:0]    i_den,
    output logic [tpc_pkg::NDIV-1:0]  o_quo
);
    import tpc_pkg::*;

    t_divst r_st [NDIV];
    t_divst n_first;

    // Seed the first stage with the numerator as remainder
    always_comb begin
        n_first.rem = i_num;
        n_first.den = i_den;
        n_first.quo = '0;
    end

    // Advance every stage one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= div_step(n_first);
            for (int k = 1; k < NDIV; k++) begin
                r_st[k] <= div_step(r_st[k-1]);
            end
        end
    end

    assign o_quo = r_st[NDIV-1].quo;

endmodule

// ----- sv/triangle_plane_clipper.sv -----
// Top level of the triangle plane clipper: distance, classify, divide, cut, emit.
// Depends on tpc_pkg and tpc_div.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream takes one triangle per word (nine Q16.16 coordinates).
//   Master stream gives zero, one or two clipped triangles per input word;
//   tlast marks the last triangle of each input.
//   The plane (point and inside normal) is loaded through the write port
//   while the block is idle; each write takes effect at the next edge.
// Pipeline: four distance and setup stages, 31 divider stages, multiply and
//   output register, from input accept to the first result word.
// Throughput: one input per cycle when each gives at most one triangle and
//   tready is high; an input giving two triangles holds the output register
//   for both, so the output port (one triangle per cycle) sets the rate.
// Reset: clears all valid bits and loads the default plane (z = 0.1, +z).
// Stall: a held word with tready low, or a pending first of a pair, freezes
//   all stages and drops s_axis_tready; nothing is lost or repeated.
//
module triangle_plane_clipper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // a.x, a.y, a.z, b.x, b.y, b.z, c.x, c.y, c.z (32 bits each, low to high)
    input  logic [tpc_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // out a.x .. out c.z (32 bits each, low to high)
    output logic [tpc_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tlast,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_wen,
    input  logic [tpc_pkg::CFG_IW-1:0]    i_cfg_idx,
    input  logic [tpc_pkg::CW-1:0]        i_cfg_wdata
);
    import tpc_pkg::*;

    logic en;

    // Plane registers
    logic [CW-1:0] r_pt [3];
    logic [CW-1:0] r_nm [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt[0] <= '0;
            r_pt[1] <= '0;
            r_pt[2] <= RST_POINT_Z;
            r_nm[0] <= '0;
            r_nm[1] <= '0;
            r_nm[2] <= RST_NORMAL_Z;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_POINT_X:  r_pt[0] <= i_cfg_wdata;
                REG_POINT_Y:  r_pt[1] <= i_cfg_wdata;
                REG_POINT_Z:  r_pt[2] <= i_cfg_wdata;
                REG_NORMAL_X: r_nm[0] <= i_cfg_wdata;
                REG_NORMAL_Y: r_nm[1] <= i_cfg_wdata;
                REG_NORMAL_Z: r_nm[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage 1: vertex minus plane point
    t_tri                     r_v1;
    logic signed [CW:0]       r_df1 [3][3];
    logic                     r_vld1;
    t_tri                     in_tri;

    assign in_tri = t_tri'(i_s_axis_tdata);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1 <= in_tri;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_df1[i][j] <= $signed({in_tri[i][j][CW-1], in_tri[i][j]})
                                 - $signed({r_pt[j][CW-1], r_pt[j]});
                end
            end
        end
    end

    // Stage 2: per-axis products with the normal
    t_tri                     r_v2;
    logic signed [2*CW:0]     r_pr2 [3][3];
    logic                     r_vld2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v2 <= r_v1;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr2[i][j] <= $signed(r_nm[j]) * r_df1[i][j];
                end
            end
        end
    end

    // Stage 3: signed distances
    t_tri                     r_v3;
    logic signed [DW-1:0]     r_d3 [3];
    logic                     r_vld3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v3 <= r_v2;
            for (int i = 0; i < 3; i++) begin
                r_d3[i] <= $signed({{2{r_pr2[i][0][2*CW]}}, r_pr2[i][0]})
                         + $signed({{2{r_pr2[i][1][2*CW]}}, r_pr2[i][1]})
                         + $signed({{2{r_pr2[i][2][2*CW]}}, r_pr2[i][2]});
            end
        end
    end

    // Stage 4: classify vertices, pick the two cut edges
    logic [1:0] ins_idx [3];
    logic [1:0] out_idx [3];
    logic [1:0] ic, oc;
    t_side      n_side4;
    logic [RW-1:0] n_num [2];
    logic [RW-1:0] n_den [2];

    always_comb begin
        ic = '0;
        oc = '0;
        for (int i = 0; i < 3; i++) begin
            ins_idx[i] = '0;
            out_idx[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (!r_d3[i][DW-1]) begin
                ins_idx[ic] = 2'(i);
                ic = ic + 2'd1;
            end else begin
                out_idx[oc] = 2'(i);
                oc = oc + 2'd1;
            end
        end
        n_side4.v   = r_v3;
        n_side4.ic  = ic;
        n_side4.ea0 = ins_idx[0];
        n_side4.eb0 = out_idx[0];
        n_side4.ea1 = (ic == 2'd2) ? ins_idx[1] : ins_idx[0];
        n_side4.eb1 = (ic == 2'd2) ? out_idx[0] : out_idx[1];
        n_num[0] = RW'($signed(r_d3[n_side4.ea0]));
        n_den[0] = RW'($signed(r_d3[n_side4.ea0])) - RW'($signed(r_d3[n_side4.eb0]));
        n_num[1] = RW'($signed(r_d3[n_side4.ea1]));
        n_den[1] = RW'($signed(r_d3[n_side4.ea1])) - RW'($signed(r_d3[n_side4.eb1]));
    end

    t_side          r_side4;
    logic [RW-1:0]  r_num4 [2];
    logic [RW-1:0]  r_den4 [2];
    logic           r_vld4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side4  <= n_side4;
            r_num4   <= n_num;
            r_den4   <= n_den;
        end
    end

    // Divider stages, side data delayed alongside
    logic [NDIV-1:0] quo [2];
    t_side           r_sideq [NDIV];
    logic            r_vldq  [NDIV];

    tpc_div u_div0 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num4[0]),
        .i_den (r_den4[0]),
        .o_quo (quo[0])
    );

    tpc_div u_div1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_num4[1]),
        .i_den (r_den4[1]),
        .o_quo (quo[1])
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sideq[0] <= r_side4;
            for (int k = 1; k < NDIV; k++) begin
                r_sideq[k] <= r_sideq[k-1];
            end
        end
    end

    // Stage 5: edge delta times t
    t_side                 sd;
    logic signed [CW:0]    n_dl [2][3];
    logic signed [PW:0]    n_pm [2][3];
    t_side                 r_side5;
    logic [PW-1:0]         r_pm5 [2][3];
    logic                  r_vld5;

    assign sd = r_sideq[NDIV-1];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_dl[0][j] = $signed({sd.v[sd.eb0][j][CW-1], sd.v[sd.eb0][j]})
                       - $signed({sd.v[sd.ea0][j][CW-1], sd.v[sd.ea0][j]});
            n_dl[1][j] = $signed({sd.v[sd.eb1][j][CW-1], sd.v[sd.eb1][j]})
                       - $signed({sd.v[sd.ea1][j][CW-1], sd.v[sd.ea1][j]});
            n_pm[0][j] = n_dl[0][j] * $signed({1'b0, quo[0]});
            n_pm[1][j] = n_dl[1][j] * $signed({1'b0, quo[1]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side5 <= sd;
            for (int e = 0; e < 2; e++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pm5[e][j] <= n_pm[e][j][PW-1:0];
                end
            end
        end
    end

    // Valid bits for every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            for (int k = 0; k < NDIV; k++) begin
                r_vldq[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld1    <= i_s_axis_tvalid;
            r_vld2    <= r_vld1;
            r_vld3    <= r_vld2;
            r_vld4    <= r_vld3;
            r_vldq[0] <= r_vld4;
            for (int k = 1; k < NDIV; k++) begin
                r_vldq[k] <= r_vldq[k-1];
            end
            r_vld5    <= r_vldq[NDIV-1];
        end
    end

    // Stage 6: finish the cut points and build the triangles
    t_vert            xp [2];
    t_tri             n_t0, n_t1;
    logic signed [CW+1:0] sum;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            for (int j = 0; j < 3; j++) begin
                sum = $signed({{2{r_side5.v[(e == 0) ? r_side5.ea0 : r_side5.ea1][j][CW-1]}},
                               r_side5.v[(e == 0) ? r_side5.ea0 : r_side5.ea1][j]})
                    + $signed({r_pm5[e][j][PW-1], r_pm5[e][j][PW-1:NDIV]});
                xp[e][j] = sat32(sum);
            end
        end
        n_t0 = r_side5.v;
        n_t1 = r_side5.v;
        case (r_side5.ic)
            2'd2: begin
                n_t0[0] = r_side5.v[r_side5.ea0];
                n_t0[1] = xp[0];
                n_t0[2] = r_side5.v[r_side5.ea1];
                n_t1[0] = r_side5.v[r_side5.ea1];
                n_t1[1] = xp[0];
                n_t1[2] = xp[1];
            end
            2'd1: begin
                n_t0[0] = r_side5.v[r_side5.ea0];
                n_t0[1] = xp[0];
                n_t0[2] = xp[1];
            end
            default: ;
        endcase
    end

    // Output register: one or two triangles, sent one word at a time
    t_tri r_t0, r_t1;
    logic r_ov, r_two, r_sel;

    assign en = !r_ov || (i_m_axis_tready && (!r_two || r_sel));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0 <= n_t0;
            r_t1 <= n_t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_two <= 1'b0;
            r_sel <= 1'b0;
        end else if (en) begin
            r_ov  <= r_vld5 && (r_side5.ic != 2'd0);
            r_two <= (r_side5.ic == 2'd2);
            r_sel <= 1'b0;
        end else if (r_ov && i_m_axis_tready) begin
            r_sel <= 1'b1;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_sel ? TDATA_W'(r_t1) : TDATA_W'(r_t0);
    assign o_m_axis_tlast  = !r_two || r_sel;

endmodule

// ----- sv/tpc_checker.sv -----
// Port-level checks for the triangle plane clipper, bound to the top level.
// Depends on tpc_pkg and triangle_plane_clipper.
`timescale 1ns / 1ps

module tpc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_axis_tready,
    input logic [tpc_pkg::TDATA_W-1:0]  o_m_axis_tdata,
    input logic                         o_m_axis_tlast,
    input logic                         o_m_axis_tvalid,
    input logic                         i_m_axis_tready
);
    import tpc_pkg::*;

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

    // An empty output register never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // The second triangle of a pair follows right after the first
    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=> o_m_axis_tvalid)
        else $error("second triangle missing");

    // Input waits while the first of a pair is pending
    a_pair_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input taken during pair");

endmodule

bind triangle_plane_clipper tpc_checker u_tpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);
